### rtl/wrs_pkg.sv
// Shared types and constants of the weighted random select block.
package wrs_pkg;

   localparam int DEF_MAX_WEIGHTS = 16;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam int SLOT_W     = 4;
   localparam int WEIGHT_W   = 16;
   localparam int RND_W      = 15;
   localparam int INDEX_W    = 4;
   localparam int CSR_W      = 5;
   localparam int CSR_RESET  = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;
   localparam int BIT_CNT_W  = $clog2(RND_W);

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

### rtl/wrs_weight_mem.sv
// Weight table memory with per-entry valid bits and a registered read port.
module wrs_weight_mem #(
   parameter int DEPTH = wrs_pkg::DEF_MAX_WEIGHTS,
   parameter int WIDTH = wrs_pkg::DEF_WEIGHT_BITS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wrs_alu.sv
// Shared adder and subtractor with carry/borrow out.
module wrs_alu #(
   parameter int W = 32
) (
   input  wrs_pkg::alu_op_type op,
   input  logic [W-1:0]        a,
   input  logic [W-1:0]        b,
   output logic [W-1:0]        res,
   output logic                carry
);

   logic [W:0] full;

   always_comb begin
      case (op)
         wrs_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
         wrs_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default:          full = '0;
      endcase
   end

   assign res   = full[W-1:0];
   assign carry = full[W];

endmodule

### rtl/weighted_random_select.sv
// Top level of the weighted random select block: sequencer and datapath.
//
// The req channel takes one word per command. A load word (tuser = 0) writes
// a weight into a table slot and gives no response. A
// draw word (tuser = 1) sums the weights of the slots in use, reduces the
// random value modulo that total and returns the first slot whose cumulative
// interval holds it. One response word leaves on the rsp channel per draw;
// tuser then flags a zero total, with index 0.
// A draw with N slots in use sums the weights through the one-read-per-cycle
// table port, runs a restoring modulo over the 15 random bits on the shared
// adder, scans the cumulative intervals of up to N slots and posts the
// result. The response is valid in the next cycle, and the block takes
// its next word in that same cycle. A zero total skips the modulo and
// the scan. req_tready stays low while a draw is in progress.
// The csr port writes the number of slots in use; write it only when idle.
// Reset clears the weight table and sets the slots in use to 16.
// The response sits in an output register; a stalled receiver lets the
// block take the next word, and a later draw waits at its end until the
// register is free.
module weighted_random_select #(
   parameter int MAX_WEIGHTS = wrs_pkg::DEF_MAX_WEIGHTS,
   parameter int WEIGHT_BITS = wrs_pkg::DEF_WEIGHT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot [3:0], weight_value [19:4], random_value [34:20]
   input  logic [wrs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // chosen_index [3:0]
   output logic [wrs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // zero_total_error [0]
   output logic                            rsp_tuser,
   input  logic                            csr_wen,
   input  logic [wrs_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int IDX_W   = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
   localparam int CNT_W   = $clog2(MAX_WEIGHTS + 1);
   localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
   localparam int RND_W   = wrs_pkg::RND_W;
   localparam int UNIT_W  = (TOTAL_W > RND_W) ? TOTAL_W : RND_W;

   wrs_pkg::state_type state_ff, state_in;

   logic [wrs_pkg::CSR_W-1:0]     wiu_ff;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   logic [IDX_W-1:0]              rd_slot_ff;
   logic [TOTAL_W-1:0]            total_ff, total_in;
   logic [RND_W-1:0]              rnd_ff, rnd_in;
   logic [RND_W-1:0]              rem_ff, rem_in;
   logic [wrs_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]              pick_ff, pick_in;
   logic                          err_ff, err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wrs_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic                          rsp_err_ff;

   logic [wrs_pkg::SLOT_W-1:0]    req_slot;
   logic [wrs_pkg::WEIGHT_W-1:0]  req_weight;
   logic [RND_W-1:0]              req_rnd;
   logic                          req_fire;
   logic                          draw_fire;
   logic                          load_fire;

   logic [CNT_W-1:0]              n_act;
   logic                          issue;
   logic                          sum_done;
   logic                          found;
   logic                          post;
   logic [RND_W-1:0]              shifted;
   logic [WEIGHT_BITS-1:0]        rd_data;

   wrs_pkg::alu_op_type           alu_op;
   logic [UNIT_W-1:0]             alu_a, alu_b, alu_res;
   logic                          alu_carry;

   assign req_slot   = req_tdata[3:0];
   assign req_weight = req_tdata[19:4];
   assign req_rnd    = req_tdata[34:20];
   assign req_fire   = req_tvalid && req_tready;
   assign draw_fire  = req_fire && (req_tuser == wrs_pkg::CMD_DRAW);
   assign load_fire  = req_fire && (req_tuser == wrs_pkg::CMD_LOAD) &&
                       (int'(req_slot) < MAX_WEIGHTS);

   always_comb begin
      if (int'(wiu_ff) > MAX_WEIGHTS) begin
         n_act = CNT_W'(MAX_WEIGHTS);
      end else begin
         n_act = CNT_W'(wiu_ff);
      end
   end

   assign shifted = {rem_ff[RND_W-2:0], rnd_ff[RND_W-1]};

   wrs_weight_mem #(
      .DEPTH(MAX_WEIGHTS),
      .WIDTH(WEIGHT_BITS),
      .AW   (IDX_W)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (load_fire),
      .wr_addr(IDX_W'(req_slot)),
      .wr_data(WEIGHT_BITS'(req_weight)),
      .rd_en  (issue),
      .rd_addr(idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   wrs_alu #(
      .W(UNIT_W)
   ) u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .res  (alu_res),
      .carry(alu_carry)
   );

   // Sequencer outputs.
   always_comb begin
      issue      = 1'b0;
      alu_op     = wrs_pkg::ALU_ADD;
      alu_a      = UNIT_W'(total_ff);
      alu_b      = UNIT_W'(rd_data);
      req_tready = 1'b0;
      post       = 1'b0;
      case (state_ff)
         wrs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         wrs_pkg::ST_SUM: begin
            issue = (idx_ff < n_act);
         end
         wrs_pkg::ST_MOD: begin
            alu_op = wrs_pkg::ALU_SUB;
            alu_a  = UNIT_W'(shifted);
            alu_b  = UNIT_W'(total_ff);
         end
         wrs_pkg::ST_SCAN: begin
            issue  = (idx_ff < n_act);
            alu_op = wrs_pkg::ALU_SUB;
            alu_a  = UNIT_W'(rem_ff);
         end
         wrs_pkg::ST_DONE: begin
            post = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign sum_done = (state_ff == wrs_pkg::ST_SUM) && !issue && !pend_ff;
   assign found    = (state_ff == wrs_pkg::ST_SCAN) && pend_ff && alu_carry;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrs_pkg::ST_IDLE: begin
            if (draw_fire) begin
               state_in = wrs_pkg::ST_SUM;
            end
         end
         wrs_pkg::ST_SUM: begin
            if (sum_done) begin
               state_in = (total_ff == '0) ? wrs_pkg::ST_DONE : wrs_pkg::ST_MOD;
            end
         end
         wrs_pkg::ST_MOD: begin
            if (bit_cnt_ff == '0) begin
               state_in = wrs_pkg::ST_SCAN;
            end
         end
         wrs_pkg::ST_SCAN: begin
            if (found || (!issue && !pend_ff)) begin
               state_in = wrs_pkg::ST_DONE;
            end
         end
         wrs_pkg::ST_DONE: begin
            if (post) begin
               state_in = wrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrs_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      idx_in     = idx_ff + CNT_W'(issue);
      pend_in    = issue;
      total_in   = total_ff;
      rnd_in     = rnd_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      pick_in    = pick_ff;
      err_in     = err_ff;
      case (state_ff)
         wrs_pkg::ST_IDLE: begin
            idx_in     = '0;
            total_in   = '0;
            rnd_in     = req_rnd;
            rem_in     = '0;
            bit_cnt_in = wrs_pkg::BIT_CNT_W'(RND_W - 1);
            pick_in    = '0;
            err_in     = 1'b0;
         end
         wrs_pkg::ST_SUM: begin
            if (pend_ff) begin
               total_in = alu_res[TOTAL_W-1:0];
            end
            if (sum_done && (total_ff == '0)) begin
               err_in = 1'b1;
            end
         end
         wrs_pkg::ST_MOD: begin
            idx_in     = '0;
            rem_in     = alu_carry ? shifted : alu_res[RND_W-1:0];
            rnd_in     = {rnd_ff[RND_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - wrs_pkg::BIT_CNT_W'(1);
         end
         wrs_pkg::ST_SCAN: begin
            if (found) begin
               pick_in = rd_slot_ff;
            end else if (pend_ff) begin
               rem_in = alu_res[RND_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrs_pkg::ST_IDLE;
         wiu_ff       <= wrs_pkg::CSR_W'(wrs_pkg::CSR_RESET);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            wiu_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_slot_ff <= idx_ff[IDX_W-1:0];
      total_ff   <= total_in;
      rnd_ff     <= rnd_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      pick_ff    <= pick_in;
      err_ff     <= err_in;
      if (post) begin
         rsp_index_ff <= wrs_pkg::INDEX_W'(pick_ff);
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = wrs_pkg::RSP_DATA_W'(rsp_index_ff);
   assign rsp_tuser  = rsp_err_ff;

   a_err_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("zero total response carries a nonzero index");

   a_scan_below_total: assert property (@(posedge clock) disable iff (reset)
      state_ff == wrs_pkg::ST_SCAN |-> UNIT_W'(rem_ff) < UNIT_W'(total_ff))
      else $error("scan remainder is not below the total");

   a_scan_not_exhausted: assert property (@(posedge clock) disable iff (reset)
      state_ff == wrs_pkg::ST_SCAN |-> issue || pend_ff)
      else $error("scan ran past the slots in use");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      draw_fire |=> !req_tready)
      else $error("ready while a draw is in progress");

endmodule
